// ===== sv/searchable_deque_top_defines.svh =====
// Assertion macros shared by the searchable deque checker.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef SEARCHABLE_DEQUE_TOP_DEFINES_SVH
`define SEARCHABLE_DEQUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define SDQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define SDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sdq_pkg.sv =====
// Shared types and constants for the searchable deque.
// No dependencies.
package sdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 5;
	localparam int DATA_W = 32;

	// Request opcodes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_FIND       = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] removed_value;
		logic [POS_W-1:0]         occupancy;
	} rsp_t;

	// Per-cell controls
	typedef struct packed {
		logic shift_back;   // take neighbor toward the front
		logic shift_front;  // take neighbor toward the back
		logic write_en;     // load the pushed value
	} cell_ctrl_t;

	// Controls from the top level into the chain
	typedef struct packed {
		logic             shift_back;
		logic             shift_front;
		logic             write_en;
		logic [IDX_W-1:0] write_idx;
	} chain_ctrl_t;

endpackage

// ===== sv/sdq_cell.sv =====
// One storage cell of the deque chain: a value register and an equality comparator.
// Depends on sdq_pkg.
module sdq_cell (
	input  logic                               clk,
	input  sdq_pkg::cell_ctrl_t                ctrl,
	input  logic signed [sdq_pkg::DATA_W-1:0]  prev_value,
	input  logic signed [sdq_pkg::DATA_W-1:0]  next_value,
	input  logic signed [sdq_pkg::DATA_W-1:0]  push_value,
	input  logic signed [sdq_pkg::DATA_W-1:0]  key,
	output logic signed [sdq_pkg::DATA_W-1:0]  value,
	output logic                               match
);

	logic signed [sdq_pkg::DATA_W-1:0] value_q;

	// Shift from a neighbor or load the pushed value
	always_ff @(posedge clk) begin
		if (ctrl.shift_back) begin
			value_q <= prev_value;
		end else if (ctrl.shift_front) begin
			value_q <= next_value;
		end else if (ctrl.write_en) begin
			value_q <= push_value;
		end
	end

	assign value = value_q;
	assign match = (value_q == key);

endmodule

// ===== sv/sdq_chain.sv =====
// Row of deque cells, front at index 0; tail select and first-match encoder.
// Depends on sdq_pkg and sdq_cell.
module sdq_chain (
	input  logic                               clk,
	input  sdq_pkg::chain_ctrl_t               ctrl,
	input  logic signed [sdq_pkg::DATA_W-1:0]  push_value,
	input  logic signed [sdq_pkg::DATA_W-1:0]  key,
	input  logic [sdq_pkg::CNT_W-1:0]          count,
	output logic signed [sdq_pkg::DATA_W-1:0]  head_value,
	output logic signed [sdq_pkg::DATA_W-1:0]  tail_value,
	output logic                               hit,
	output logic [sdq_pkg::IDX_W-1:0]          hit_idx
);

	logic signed [sdq_pkg::DATA_W-1:0] val_w [sdq_pkg::DEPTH];
	logic [sdq_pkg::DEPTH-1:0]         match_w;

	// Cell row; neighbors feed each other, the ends see the push value and zero
	for (genvar i = 0; i < sdq_pkg::DEPTH; i++) begin : g_cell
		sdq_pkg::cell_ctrl_t               cctl;
		logic signed [sdq_pkg::DATA_W-1:0] prev_w;
		logic signed [sdq_pkg::DATA_W-1:0] next_w;

		assign cctl.shift_back  = ctrl.shift_back;
		assign cctl.shift_front = ctrl.shift_front;
		assign cctl.write_en    = ctrl.write_en && (ctrl.write_idx == sdq_pkg::IDX_W'(i));

		if (i == 0) begin : g_head
			assign prev_w = push_value;
		end else begin : g_body
			assign prev_w = val_w[i-1];
		end

		if (i == sdq_pkg::DEPTH - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = val_w[i+1];
		end

		sdq_cell u_cell (
			.clk        (clk),
			.ctrl       (cctl),
			.prev_value (prev_w),
			.next_value (next_w),
			.push_value (push_value),
			.key        (key),
			.value      (val_w[i]),
			.match      (match_w[i])
		);
	end

	assign head_value = val_w[0];

	// Tail is the cell at count-1; AND-OR select
	always_comb begin
		tail_value = '0;
		for (int i = 0; i < sdq_pkg::DEPTH; i++) begin
			if (count == sdq_pkg::CNT_W'(i + 1)) begin
				tail_value = tail_value | val_w[i];
			end
		end
	end

	// First occupied cell that matches, nearest the front wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = sdq_pkg::DEPTH - 1; i >= 0; i--) begin
			if (match_w[i] && (sdq_pkg::CNT_W'(i) < count)) begin
				hit     = 1'b1;
				hit_idx = sdq_pkg::IDX_W'(i);
			end
		end
	end

endmodule

// ===== sv/searchable_deque_top.sv =====
// Top level of the searchable deque: request decode, count register, result register.
// Depends on sdq_pkg, sdq_chain and sdq_cell.

// Bounded deque of 16 signed 32-bit values with push/pop at either end and a
// find that returns the 1-based position of the first equal element. Every
// request beat yields exactly one response beat, registered on acceptance. A new
// request is taken every cycle while the response register is empty or being
// drained, so throughput is one request per cycle; req_stall rises only when a
// response is held by rsp_stall. Each cell of the chain shifts and loads through
// its register and compares combinationally, so the cycle time is set by the
// per-cell 32-bit compare followed by the 16-entry first-match encoder.
// Stored values have no reset; only occupied cells are ever reported.
module searchable_deque_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sdq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sdq_pkg::rsp_t  rsp
);

	logic [sdq_pkg::CNT_W-1:0]         count_q;
	logic [sdq_pkg::CNT_W-1:0]         count_d;
	logic                              rsp_valid_q;
	sdq_pkg::rsp_t                     rsp_q;
	sdq_pkg::rsp_t                     rsp_d;
	sdq_pkg::chain_ctrl_t              ctrl;
	logic                              accept;
	logic                              full;
	logic                              empty;
	logic signed [sdq_pkg::DATA_W-1:0] head_value;
	logic signed [sdq_pkg::DATA_W-1:0] tail_value;
	logic                              hit;
	logic [sdq_pkg::IDX_W-1:0]         hit_idx;

	// Take a request unless a finished response is stuck
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == sdq_pkg::CNT_W'(sdq_pkg::DEPTH));
	assign empty     = (count_q == '0);

	// Request decode
	always_comb begin
		ctrl                = '0;
		ctrl.write_idx      = count_q[sdq_pkg::IDX_W-1:0];
		count_d             = count_q;
		rsp_d.status        = sdq_pkg::ST_OK;
		rsp_d.position      = '0;
		rsp_d.removed_value = '0;
		case (req.opcode)
			sdq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					rsp_d.status = sdq_pkg::ST_FULL;
				end else begin
					ctrl.shift_back = accept;
					count_d         = count_q + sdq_pkg::CNT_W'(1);
				end
			end
			sdq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					rsp_d.status = sdq_pkg::ST_FULL;
				end else begin
					ctrl.write_en = accept;
					count_d       = count_q + sdq_pkg::CNT_W'(1);
				end
			end
			sdq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					rsp_d.status = sdq_pkg::ST_EMPTY;
				end else begin
					ctrl.shift_front    = accept;
					rsp_d.removed_value = head_value;
					count_d             = count_q - sdq_pkg::CNT_W'(1);
				end
			end
			sdq_pkg::OP_POP_BACK: begin
				if (empty) begin
					rsp_d.status = sdq_pkg::ST_EMPTY;
				end else begin
					rsp_d.removed_value = tail_value;
					count_d             = count_q - sdq_pkg::CNT_W'(1);
				end
			end
			sdq_pkg::OP_FIND: begin
				if (empty) begin
					rsp_d.status = sdq_pkg::ST_EMPTY;
				end else if (hit) begin
					rsp_d.position = sdq_pkg::POS_W'(hit_idx) + sdq_pkg::POS_W'(1);
				end else begin
					rsp_d.status = sdq_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		rsp_d.occupancy = sdq_pkg::POS_W'(count_d);
	end

	sdq_chain u_chain (
		.clk        (clk),
		.ctrl       (ctrl),
		.push_value (req.value),
		.key        (req.value),
		.count      (count_q),
		.head_value (head_value),
		.tail_value (tail_value),
		.hit        (hit),
		.hit_idx    (hit_idx)
	);

	// Element count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/sdq_checker.sv =====
// Port-level checks for the searchable deque, bound to the top level.
// Depends on sdq_pkg and searchable_deque_top_defines.svh.
`include "searchable_deque_top_defines.svh"

module sdq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sdq_pkg::rsp_t rsp
);

	logic rsp_full;
	logic rsp_empty;
	logic rsp_hit;
	logic at_cap;
	logic rsp_blank;
	logic hit_ok;

	// Response beat classification
	assign rsp_full  = rsp_valid && (rsp.status == sdq_pkg::ST_FULL);
	assign rsp_empty = rsp_valid && (rsp.status == sdq_pkg::ST_EMPTY);
	assign rsp_hit   = rsp_valid && (rsp.position != '0);
	assign at_cap    = (rsp.occupancy == sdq_pkg::POS_W'(sdq_pkg::DEPTH));
	assign rsp_blank = (rsp.occupancy == '0) && (rsp.removed_value == '0);
	assign hit_ok    = (rsp.status == sdq_pkg::ST_OK) && (rsp.position <= rsp.occupancy);

	// A held response stays valid
	`SDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

	// Requests are only back-pressured by a stuck response
	`SDQ_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without cause")

	// Full only at capacity
	`SDQ_ASSERT_NOW(a_full_occ, rsp_full, at_cap, "full status below capacity")

	// Empty leaves nothing stored
	`SDQ_ASSERT_NOW(a_empty_occ, rsp_empty, rsp_blank, "empty status with data")

	// A hit lies inside the stored range
	`SDQ_ASSERT_NOW(a_pos_range, rsp_hit, hit_ok, "find position out of range")

endmodule

bind searchable_deque_top sdq_checker u_sdq_checker (.*);
